FILE: sv/bscs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the binned spectrum CDF sampler.
package bscs_pkg;

    // Stream payload widths (tdata padded to whole bytes)
    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 72;

    // Cumulative weight width and saturation value
    localparam int             CUM_W   = 40;
    localparam logic [CUM_W-1:0] CUM_MAX = {CUM_W{1'b1}};

    // Energy limits
    localparam logic [30:0] ENERGY_MAX = 31'h7FFF_FFFF;
    localparam logic [30:0] ENERGY_MIN = 31'd1;

    // Request kinds carried on s_axis_tuser
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_SAMPLE = 2'd2;

    // Result status carried on m_axis_tuser
    localparam logic [1:0] STAT_SAMPLED  = 2'd0;
    localparam logic [1:0] STAT_FALLBACK = 2'd1;
    localparam logic [1:0] STAT_STORED   = 2'd2;
    localparam logic [1:0] STAT_DROPPED  = 2'd3;

    // Register file
    localparam int          APB_AW         = 3;
    localparam logic [0:0]  REG_FALLBACK   = 1'b0;
    localparam logic [30:0] FALLBACK_RESET = 31'd4454;

    // Controller to datapath commands
    typedef struct packed {
        logic       cap_in;
        logic       clear;
        logic       append;
        logic       res_fixed;
        logic [1:0] res_code;
        logic       mul_lo;
        logic       mul_hi;
        logic       sum;
        logic       scan;
        logic       spread;
        logic       res_sample;
        logic       load_out;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] req;
        logic       fallback_case;
        logic       table_full;
        logic       scan_hit;
    } t_dp_sts;

endpackage

FILE: sv/binned_spectrum_cdf_sampler.sv
`timescale 1ns / 1ps
// Top level: binned spectrum sampler with stream channels and register port.
// Usage:
//   s_axis carries requests: tuser selects clear, append bin or draw a sample;
//   tdata carries the bin fields and the two random fractions.
//   m_axis returns one result item per request (none for an unused kind):
//   tuser holds the status, tdata the energy, polarisation and bin index.
//   The register port holds fallback_energy at byte address 0.
// Sequence:
//   Clear, append and a fallback sample go from decode straight to the
//   output step. A sample passes through the two multiply steps, the sum, a
//   walk over the cumulative weight memory, one entry per cycle, up to the
//   chosen bin, then the spread and final steps; the walk grows with the
//   index of the chosen bin.
//   One item is in work at a time; the next is taken once the result has
//   moved into the output register, even while that register waits.
// Reset: synchronous, active low. The table is empty, fallback_energy is 4454;
//   table memories are not cleared, only entries below the bin count are read.
// Stall: while m_axis_tready is low the result holds and the block stops taking
//   items once a further finished result is waiting behind it.
module binned_spectrum_cdf_sampler #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Request channel
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] edge_low, [63:32] edge_high, [95:64] bin_weight,
    // [111:96] pol_mean_in, [127:112] pol_sigma_in, [151:128] rand_pick,
    // [167:152] rand_spread
    input  logic [bscs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]                         s_axis_tuser,
    // Result channel
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [30:0] energy, [46:31] pol_mean_out, [62:47] pol_sigma_out,
    // [70:63] chosen_bin, [71] zero
    output logic [bscs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [1:0] status
    output logic [1:0]                         m_axis_tuser,
    // Register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bscs_pkg::APB_AW-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic [30:0]       r_fallback;
    logic [0:0]        reg_idx;
    bscs_pkg::t_dp_cmd cmd;
    bscs_pkg::t_dp_sts sts;

    // Register port: single register, always ready
    assign pready  = 1'b1;
    assign reg_idx = paddr[bscs_pkg::APB_AW-1:2];
    assign prdata  = (reg_idx == bscs_pkg::REG_FALLBACK) ? {1'b0, r_fallback} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fallback <= bscs_pkg::FALLBACK_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (reg_idx == bscs_pkg::REG_FALLBACK)) begin
            r_fallback <= pwdata[30:0];
        end
    end

    bscs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    bscs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_req_type        (s_axis_tuser),
        .i_in_data         (s_axis_tdata),
        .i_fallback_energy (r_fallback),
        .o_out_status      (m_axis_tuser),
        .o_out_data        (m_axis_tdata)
    );

endmodule

FILE: sv/bscs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module bscs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/bscs_dp.sv
`timescale 1ns / 1ps
// Datapath: bin tables, running totals, pick scaling, CDF scan and energy spread.
module bscs_dp #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bscs_pkg::t_dp_cmd                  i_cmd,
    output bscs_pkg::t_dp_sts                  o_sts,
    input  logic [1:0]                         i_req_type,
    input  logic [bscs_pkg::IN_DATA_W-1:0]     i_in_data,
    input  logic [30:0]                        i_fallback_energy,
    output logic [1:0]                         o_out_status,
    output logic [bscs_pkg::OUT_DATA_W-1:0]    o_out_data
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int CUM_W = bscs_pkg::CUM_W;
    localparam int BIN_W = 96;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // Captured item
    logic [1:0]        r_req;
    logic [31:0]       r_edge_low;
    logic [31:0]       r_edge_high;
    logic [31:0]       r_weight;
    logic [15:0]       r_pm_in;
    logic [15:0]       r_ps_in;
    logic [23:0]       r_pick;
    logic [15:0]       r_spread;

    // Table bookkeeping
    logic [CW-1:0]     r_count;
    logic [CUM_W-1:0]  r_total;

    // Pick scaling
    logic [43:0]       r_prod_lo;
    logic [43:0]       r_prod_hi;
    logic [CUM_W-1:0]  r_u;

    // Scan pipeline
    logic [IW-1:0]     r_scan_addr;
    logic [IW-1:0]     r_tag;
    logic              r_tag_vld;

    // Chosen bin
    logic [31:0]       r_lo;
    logic signed [32:0] r_diff;
    logic [15:0]       r_pm;
    logic [15:0]       r_ps;
    logic [IW-1:0]     r_idx;
    logic signed [49:0] r_sp_prod;

    // Staged result and output register
    logic [1:0]        r_res_status;
    logic [30:0]       r_res_energy;
    logic [15:0]       r_res_pm;
    logic [15:0]       r_res_ps;
    logic [7:0]        r_res_bin;
    logic [1:0]        r_out_status;
    logic [30:0]       r_out_energy;
    logic [15:0]       r_out_pm;
    logic [15:0]       r_out_ps;
    logic [7:0]        r_out_bin;

    logic [19:0]       mul_b;
    logic [43:0]       mul_p;
    logic [63:0]       pick_full;
    logic [31:0]       w_pos;
    logic [CUM_W:0]    cum_sum;
    logic [CUM_W-1:0]  cum_sat;
    logic              table_full;
    logic              fallback_case;
    logic [CW-1:0]     last_cnt;
    logic              scan_hit;
    logic              ram_we;
    logic [CUM_W-1:0]  cum_rdata;
    logic [BIN_W-1:0]  bin_rdata;
    logic [BIN_W-1:0]  bin_wdata;
    logic [31:0]       rd_lo;
    logic [31:0]       rd_hi;
    logic signed [34:0] e_sum;
    logic [30:0]       e_clamp;
    logic [IW+7:0]     idx_ext;

    // Status towards the controller
    assign table_full    = (r_count >= DEPTH_C);
    assign fallback_case = (r_count == '0) || (r_total == '0);
    assign last_cnt      = r_count - CW'(1);
    assign scan_hit      = i_cmd.scan && r_tag_vld &&
                           ((r_u <= cum_rdata) || (r_tag == last_cnt[IW-1:0]));

    assign o_sts.req           = r_req;
    assign o_sts.fallback_case = fallback_case;
    assign o_sts.table_full    = table_full;
    assign o_sts.scan_hit      = scan_hit;

    // Shared 24x20 multiplier for the two halves of the total
    assign mul_b     = i_cmd.mul_hi ? r_total[39:20] : r_total[19:0];
    assign mul_p     = {20'd0, r_pick} * {24'd0, mul_b};
    assign pick_full = {r_prod_hi, 20'd0} + {20'd0, r_prod_lo};

    // Append: clipped weight added with saturation
    assign w_pos   = r_weight[31] ? 32'd0 : r_weight;
    assign cum_sum = {1'b0, r_total} + {9'd0, w_pos};
    assign cum_sat = cum_sum[CUM_W] ? bscs_pkg::CUM_MAX : cum_sum[CUM_W-1:0];

    // Table memories, read at the scan address
    assign ram_we    = i_cmd.append && !table_full;
    assign bin_wdata = {r_ps_in, r_pm_in, r_edge_high, r_edge_low};

    bscs_ram #(
        .WIDTH (CUM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_cum_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (cum_sat),
        .i_raddr (r_scan_addr),
        .o_rdata (cum_rdata)
    );

    bscs_ram #(
        .WIDTH (BIN_W),
        .DEPTH (TABLE_DEPTH)
    ) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (bin_wdata),
        .i_raddr (r_scan_addr),
        .o_rdata (bin_rdata)
    );

    assign rd_lo = bin_rdata[31:0];
    assign rd_hi = bin_rdata[63:32];

    // Energy: low edge plus floored offset, then clamp
    assign e_sum = $signed({{3{r_lo[31]}}, r_lo}) +
                   $signed({r_sp_prod[49], r_sp_prod[49:16]});

    always_comb begin
        if (e_sum[34]) begin
            e_clamp = bscs_pkg::ENERGY_MIN;
        end else if (e_sum[33:31] != 3'd0) begin
            e_clamp = bscs_pkg::ENERGY_MAX;
        end else begin
            e_clamp = e_sum[30:0];
        end
    end

    assign idx_ext = {8'd0, r_idx};

    // Table control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_total   <= '0;
            r_tag_vld <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
                r_total <= '0;
            end else if (ram_we) begin
                r_count <= r_count + CW'(1);
                r_total <= cum_sat;
            end
            if (i_cmd.sum) begin
                r_tag_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_tag_vld <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_req       <= i_req_type;
            r_edge_low  <= i_in_data[31:0];
            r_edge_high <= i_in_data[63:32];
            r_weight    <= i_in_data[95:64];
            r_pm_in     <= i_in_data[111:96];
            r_ps_in     <= i_in_data[127:112];
            r_pick      <= i_in_data[151:128];
            r_spread    <= i_in_data[167:152];
        end
        if (i_cmd.mul_lo) begin
            r_prod_lo <= mul_p;
        end
        if (i_cmd.mul_hi) begin
            r_prod_hi <= mul_p;
        end
        if (i_cmd.sum) begin
            r_u         <= pick_full[63:24];
            r_scan_addr <= '0;
        end else if (i_cmd.scan) begin
            r_scan_addr <= r_scan_addr + IW'(1);
            r_tag       <= r_scan_addr;
        end
        if (scan_hit) begin
            r_lo   <= rd_lo;
            r_diff <= $signed({rd_hi[31], rd_hi}) - $signed({rd_lo[31], rd_lo});
            r_pm   <= bin_rdata[79:64];
            r_ps   <= bin_rdata[95:80];
            r_idx  <= r_tag;
        end
        if (i_cmd.spread) begin
            r_sp_prod <= $signed({{17{r_diff[32]}}, r_diff}) * $signed({34'd0, r_spread});
        end
        if (i_cmd.res_fixed) begin
            r_res_status <= i_cmd.res_code;
            r_res_energy <= (i_cmd.res_code == bscs_pkg::STAT_FALLBACK) ?
                            i_fallback_energy : 31'd0;
            r_res_pm     <= 16'd0;
            r_res_ps     <= 16'd0;
            r_res_bin    <= 8'd0;
        end else if (i_cmd.res_sample) begin
            r_res_status <= bscs_pkg::STAT_SAMPLED;
            r_res_energy <= e_clamp;
            r_res_pm     <= r_pm;
            r_res_ps     <= r_ps;
            r_res_bin    <= idx_ext[7:0];
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_energy <= r_res_energy;
            r_out_pm     <= r_res_pm;
            r_out_ps     <= r_res_ps;
            r_out_bin    <= r_res_bin;
        end
    end

    assign o_out_status = r_out_status;
    assign o_out_data   = {1'b0, r_out_bin, r_out_ps, r_out_pm, r_out_energy};

    // An append with room grows the table by exactly one bin
    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.append && !table_full) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("bin count did not advance on append");

    // Total weight only falls on a clear
    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.clear |=> (r_total >= $past(r_total)))
        else $error("total weight decreased without clear");

    // The scan never settles on a bin beyond the table
    a_hit_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_hit |-> (CW'(r_tag) < r_count))
        else $error("scan chose a bin outside the table");

endmodule

FILE: sv/bscs_ctrl.sv
`timescale 1ns / 1ps
// Controller: request sequencing, scan control and output handshake.
module bscs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output bscs_pkg::t_dp_cmd o_cmd,
    input  bscs_pkg::t_dp_sts i_sts
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_MUL_LO = 9'b000000100,
        S_MUL_HI = 9'b000001000,
        S_SUM    = 9'b000010000,
        S_SCAN   = 9'b000100000,
        S_SPREAD = 9'b001000000,
        S_FINAL  = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   load_out;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign load_out   = (r_state == S_OUT) && (!r_out_valid || i_m_tready);

    // Next state and commands
    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        o_cmd.load_out = load_out;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.req)
                    bscs_pkg::REQ_CLEAR: begin
                        o_cmd.clear     = 1'b1;
                        o_cmd.res_fixed = 1'b1;
                        o_cmd.res_code  = bscs_pkg::STAT_STORED;
                        n_state         = S_OUT;
                    end
                    bscs_pkg::REQ_APPEND: begin
                        o_cmd.res_fixed = 1'b1;
                        if (i_sts.table_full) begin
                            o_cmd.res_code = bscs_pkg::STAT_DROPPED;
                        end else begin
                            o_cmd.append   = 1'b1;
                            o_cmd.res_code = bscs_pkg::STAT_STORED;
                        end
                        n_state = S_OUT;
                    end
                    bscs_pkg::REQ_SAMPLE: begin
                        if (i_sts.fallback_case) begin
                            o_cmd.res_fixed = 1'b1;
                            o_cmd.res_code  = bscs_pkg::STAT_FALLBACK;
                            n_state         = S_OUT;
                        end else begin
                            n_state = S_MUL_LO;
                        end
                    end
                    default: begin
                        // unused request kind: dropped without a result
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_hit) begin
                    n_state = S_SPREAD;
                end
            end
            S_SPREAD: begin
                o_cmd.spread = 1'b1;
                n_state      = S_FINAL;
            end
            S_FINAL: begin
                o_cmd.res_sample = 1'b1;
                n_state          = S_OUT;
            end
            S_OUT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // A finished item waits while the output register is still occupied
    a_out_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !i_m_tready) |=> (r_state == S_OUT))
        else $error("result left before output register was free");

    // A sample always reaches the sum step through the two multiply steps
    a_mul_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_LO) |=> ##1 (r_state == S_SUM))
        else $error("multiply sequence broken");

endmodule
